[hdl/lpp_pkg.sv]
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared constants, types and header/rate helpers of the LPCM PES packetizer.
// ----------------------------------------------------------------------------
package lpp_pkg;

  localparam int PACKET_BYTES = 2048;
  localparam int HEADER_BYTES = 32;
  localparam int PAYLOAD_ROOM = PACKET_BYTES - HEADER_BYTES;
  // smallest nonzero subframe: 40 frames, one channel, 16-bit
  localparam int MIN_SUBFRAME = 80;
  localparam int PLEN_W       = $clog2(PACKET_BYTES);
  localparam int SPP_W        = $clog2(PAYLOAD_ROOM / MIN_SUBFRAME + 1);
  localparam int SUB_W        = 14;
  localparam int GROUP_MAX    = 12;
  localparam int GIDX_W       = $clog2(GROUP_MAX);
  localparam int HIDX_W       = $clog2(HEADER_BYTES);
  localparam int FC_W         = 5;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 4;

  typedef logic [7:0] byte_t;
  typedef logic [GROUP_MAX-1:0][7:0] group_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHANNELS = 2'd0,
    REG_RATE     = 2'd1,
    REG_WIDE     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HEADER,
    BK_PAYLOAD
  } back_state_t;

  typedef struct packed {
    logic [3:0] channels;
    logic [2:0] rate;
    logic       wide;
  } cfg_t;

  typedef struct packed {
    logic              busy;
    logic [SPP_W-1:0]  spp;
    logic [PLEN_W-1:0] plen;
  } setup_t;

  // 24-bit regrouping: high/middle pairs of four samples, then low bytes
  localparam logic [GIDX_W-1:0] ORDER24 [GROUP_MAX] = '{
    4'd2, 4'd1, 4'd5, 4'd4, 4'd8, 4'd7, 4'd11, 4'd10, 4'd0, 4'd3, 4'd6, 4'd9
  };

  function automatic logic [7:0] rate_frames(input logic [2:0] code);
    logic [7:0] f;
    case (code)
      3'd0, 3'd3: f = 8'd40;
      3'd1, 3'd4: f = 8'd80;
      3'd2, 3'd5: f = 8'd160;
      default:    f = 8'd0;
    endcase
    return f;
  endfunction

  function automatic byte_t rate_bits(input logic [2:0] code);
    byte_t r;
    case (code)
      3'd1:    r = 8'h10;
      3'd2:    r = 8'h20;
      3'd3:    r = 8'h80;
      3'd4:    r = 8'h90;
      3'd5:    r = 8'hA0;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_t hdr_byte(input logic [HIDX_W-1:0] idx,
                                     input logic [PLEN_W-1:0] plen,
                                     input logic first,
                                     input logic [FC_W-1:0] fc,
                                     input cfg_t cfg);
    logic [15:0] plen16;
    byte_t b;
    plen16 = 16'(plen) + 16'd26;
    case (idx)
      5'd0:    b = 8'h00;
      5'd1:    b = 8'h00;
      5'd2:    b = 8'h01;
      5'd3:    b = 8'hBD;
      5'd4:    b = plen16[15:8];
      5'd5:    b = plen16[7:0];
      5'd6:    b = 8'h81;
      5'd7:    b = first ? 8'h81 : 8'h01;
      5'd8:    b = 8'h09;
      5'd9:    b = 8'h21;
      5'd10:   b = 8'h00;
      5'd11:   b = 8'h01;
      5'd12:   b = 8'h00;
      5'd13:   b = 8'h01;
      5'd14:   b = first ? 8'h1E : 8'hFF;
      5'd15:   b = first ? 8'h60 : 8'hFF;
      5'd16:   b = first ? 8'h0A : 8'hFF;
      5'd17:   b = 8'hFF;
      5'd18:   b = 8'hA0;
      5'd19:   b = {3'b000, fc};
      5'd20:   b = 8'h00;
      5'd21:   b = 8'h0A;
      5'd22:   b = 8'h00;
      5'd23:   b = 8'h09;
      5'd24:   b = 8'h00;
      5'd25:   b = cfg.wide ? 8'h2F : 8'h0F;
      5'd26:   b = 8'h0F | rate_bits(cfg.rate);
      5'd27:   b = 8'h00;
      5'd28:   b = {4'h0, cfg.channels} - 8'd1;
      5'd29:   b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[hdl/lpp_setup.sv]
// ----------------------------------------------------------------------------
// lpp_setup
// Derives subframes per packet and payload length by repeated subtraction.
// ----------------------------------------------------------------------------
module lpp_setup
  import lpp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  cfg_t   cfg,
  output setup_t info
);

  logic [SUB_W-1:0]  prod;
  logic [SUB_W-1:0]  sub;
  logic [PLEN_W-1:0] rem;
  logic              busy;
  logic [SPP_W-1:0]  spp;
  logic [PLEN_W-1:0] plen;

  assign prod = SUB_W'(rate_frames(cfg.rate)) * SUB_W'(cfg.channels);
  assign sub  = cfg.wide ? (prod + (prod << 1)) : (prod << 1);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      rem  <= PLEN_W'(PAYLOAD_ROOM);
      spp  <= '0;
      plen <= '0;
    end else if (busy) begin
      if (sub != '0 && SUB_W'(rem) >= sub) begin
        rem  <= rem - PLEN_W'(sub);
        spp  <= spp + 1'b1;
        plen <= plen + PLEN_W'(sub);
      end else begin
        busy <= 1'b0;
      end
    end
  end

  assign info.busy = busy;
  assign info.spp  = spp;
  assign info.plen = plen;

endmodule

[hdl/lpp_front.sv]
// ----------------------------------------------------------------------------
// lpp_front
// Collects input bytes into sample groups and reorders them for output.
// ----------------------------------------------------------------------------
module lpp_front
  import lpp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   flush,
  input  cfg_t   cfg,
  input  setup_t info,
  input  logic   s_tvalid,
  output logic   s_tready,
  input  byte_t  s_tdata,   // pcm_byte
  input  logic   q_full,
  output logic   push,
  output group_t push_group
);

  group_t            buffer;
  group_t            whole;
  logic [GIDX_W-1:0] fill;
  logic [GIDX_W-1:0] glast;
  logic              spp_zero;
  logic              take;

  assign spp_zero = (info.spp == '0);
  assign s_tready = !info.busy && (spp_zero || !q_full);
  assign take     = s_tvalid && s_tready && !spp_zero;
  assign glast    = cfg.wide ? GIDX_W'(GROUP_MAX - 1) : GIDX_W'(1);
  assign push     = take && (fill == glast);

  always_comb begin
    whole       = buffer;
    whole[fill] = s_tdata;
    push_group  = whole;
    if (cfg.wide) begin
      for (int i = 0; i < GROUP_MAX; i++) begin
        push_group[i] = whole[ORDER24[i]];
      end
    end else begin
      push_group[0] = whole[1];
      push_group[1] = whole[0];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      buffer[fill] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      fill <= '0;
    end else if (take) begin
      fill <= push ? '0 : fill + 1'b1;
    end
  end

endmodule

[hdl/lpp_queue.sv]
// ----------------------------------------------------------------------------
// lpp_queue
// Short group queue between the collecting front and the emitting back.
// ----------------------------------------------------------------------------
module lpp_queue
  import lpp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   flush,
  input  logic   push,
  input  group_t push_group,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output group_t head_group
);

  group_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_group = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/lpp_back.sv]
// ----------------------------------------------------------------------------
// lpp_back
// Emits packet headers and queued payload groups through an output register.
// ----------------------------------------------------------------------------
module lpp_back
  import lpp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   flush,
  input  cfg_t   cfg,
  input  setup_t info,
  input  logic   head_valid,
  input  group_t head_group,
  output logic   pop,
  output logic   m_tvalid,
  input  logic   m_tready,
  output byte_t  m_tdata,   // out_byte
  output logic   m_tlast    // packet_last
);

  back_state_t       state, state_next;
  logic [HIDX_W-1:0] idx, idx_next;
  logic [PLEN_W-1:0] count, count_next;
  logic [PLEN_W-1:0] count_inc;
  logic              first, first_next;
  logic [FC_W-1:0]   fc, fc_next;
  logic              load;
  byte_t             byte_next;
  logic              last_next;
  logic              advance;
  logic [HIDX_W-1:0] glast;

  assign advance   = !m_tvalid || m_tready;
  assign glast     = cfg.wide ? HIDX_W'(GROUP_MAX - 1) : HIDX_W'(1);
  assign count_inc = count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      state <= BK_IDLE;
      idx   <= '0;
      count <= '0;
      first <= 1'b1;
      fc    <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      count <= count_next;
      first <= first_next;
      fc    <= fc_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    count_next = count;
    first_next = first;
    fc_next    = fc;
    pop        = 1'b0;
    load       = 1'b0;
    byte_next  = '0;
    last_next  = 1'b0;
    case (state)
      BK_IDLE: begin
        if (head_valid) begin
          state_next = (count == '0) ? BK_HEADER : BK_PAYLOAD;
          idx_next   = '0;
        end
      end
      BK_HEADER: begin
        if (advance) begin
          load      = 1'b1;
          byte_next = hdr_byte(idx, info.plen, first, fc, cfg);
          if (idx == HIDX_W'(HEADER_BYTES - 1)) begin
            state_next = BK_PAYLOAD;
            idx_next   = '0;
            first_next = 1'b0;
            fc_next    = fc + FC_W'(info.spp);
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      BK_PAYLOAD: begin
        if (advance) begin
          load       = 1'b1;
          byte_next  = head_group[idx[GIDX_W-1:0]];
          last_next  = (count_inc >= info.plen);
          count_next = last_next ? '0 : count_inc;
          if (idx == glast) begin
            pop        = 1'b1;
            state_next = BK_IDLE;
            idx_next   = '0;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= byte_next;
      m_tlast <= last_next;
    end
  end

endmodule

[hdl/lpcm_pes_packetizer.sv]
// ----------------------------------------------------------------------------
// lpcm_pes_packetizer
// Packs little-endian PCM bytes into DVD LPCM PES packets, one byte out each.
// ----------------------------------------------------------------------------
// path: a group's first byte reaches m_tdata through the queue, the back's idle state
//   and the output register, after the 32 header bytes when the group opens a packet
// throughput: one output byte per cycle while m_tready holds, with an idle state between
//   groups; input takes one byte per cycle while the two-group queue has room
// reset and each write to a listed register clear the stream and derive the packet
//   size by repeated subtraction, with s_tready low
module lpcm_pes_packetizer
  import lpp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  byte_t                  s_tdata,   // [7:0] pcm_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output byte_t                  m_tdata,   // [7:0] out_byte
  output logic                   m_tlast    // packet_last
);

  cfg_t   cfg;
  setup_t info;
  logic   cfg_write;
  logic   restart;
  logic   q_push;
  group_t q_push_group;
  logic   q_full;
  logic   q_pop;
  logic   q_head_valid;
  group_t q_head_group;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  // indexes beyond the register list are taken and ignored
  assign restart   = cfg_write && (cfg_index == REG_CHANNELS || cfg_index == REG_RATE ||
                                   cfg_index == REG_WIDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channels <= 4'd2;
      cfg.rate     <= 3'd0;
      cfg.wide     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_CHANNELS: cfg.channels <= cfg_data[3:0];
        REG_RATE:     cfg.rate     <= cfg_data[2:0];
        REG_WIDE:     cfg.wide     <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  lpp_setup u_setup (
    .clk   (clk),
    .rst   (rst),
    .start (restart),
    .cfg   (cfg),
    .info  (info)
  );

  lpp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .flush      (restart),
    .cfg        (cfg),
    .info       (info),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .q_full     (q_full),
    .push       (q_push),
    .push_group (q_push_group)
  );

  lpp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .flush      (restart),
    .push       (q_push),
    .push_group (q_push_group),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_group (q_head_group)
  );

  lpp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .flush      (restart),
    .cfg        (cfg),
    .info       (info),
    .head_valid (q_head_valid),
    .head_group (q_head_group),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

`ifndef SYNTHESIS
  a_no_input_while_sizing: assert property (@(posedge clk) disable iff (rst)
    info.busy |-> !s_tready)
    else $error("input taken while packet size is being derived");

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (!q_full || q_pop))
    else $error("group pushed into a full queue");

  a_restart_clears_output: assert property (@(posedge clk) disable iff (rst)
    restart |=> !m_tvalid)
    else $error("output still valid after stream restart");
`endif

endmodule

[bench/tb_lpcm_pes_packetizer.sv]
// ----------------------------------------------------------------------------
// tb_lpcm_pes_packetizer
// Streams PCM bytes through the packetizer under several channel, rate and
// sample-width settings and checks every packet byte and its packet_last
// flag against an in-bench prediction of the packet stream.
// ----------------------------------------------------------------------------
module tb_lpcm_pes_packetizer;
  import lpp_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_NONE = 2'd3;

  localparam logic [2:0] RATE_48K    = 3'd0;
  localparam logic [2:0] RATE_96K    = 3'd1;
  localparam logic [2:0] RATE_192K   = 3'd2;
  localparam logic [2:0] RATE_44K1   = 3'd3;
  localparam logic [2:0] RATE_88K2   = 3'd4;
  localparam logic [2:0] RATE_176K4  = 3'd5;
  localparam logic [2:0] RATE_RSVD6  = 3'd6;
  localparam logic [2:0] RATE_RSVD7  = 3'd7;

  localparam int SETTLE_CYCLES = 10;
  localparam int RUN_LIMIT     = 20 * 1000000;

  // output position -> input byte of a 12-byte group of 24-bit samples
  localparam int REGROUP_24 [12] = '{2, 1, 5, 4, 8, 7, 11, 10, 0, 3, 6, 9};

  typedef struct {
    byte_t data;
    logic  last;
  } pes_beat_t;

  class packet_stream_sb;
    logic [3:0]  channels;
    logic [2:0]  rate;
    logic        wide;
    byte_t       grp [12];
    int unsigned fill;
    int unsigned payload_cnt;
    int unsigned payload_len;
    int unsigned spp;
    logic        first_pkt;
    logic [4:0]  fc;
    pes_beat_t   expected_beats [$];
    int          errors;

    function new();
      channels = 4'd2;
      rate     = RATE_48K;
      wide     = 1'b0;
      errors   = 0;
      restart();
    endfunction

    function int unsigned subframe_frames(logic [2:0] r);
      case (r)
        RATE_48K, RATE_44K1:   return 40;
        RATE_96K, RATE_88K2:   return 80;
        RATE_192K, RATE_176K4: return 160;
        default:               return 0;
      endcase
    endfunction

    function byte_t rate_flags(logic [2:0] r);
      case (r)
        RATE_96K:   return 8'h10;
        RATE_192K:  return 8'h20;
        RATE_44K1:  return 8'h80;
        RATE_88K2:  return 8'h90;
        RATE_176K4: return 8'hA0;
        default:    return 8'h00;
      endcase
    endfunction

    function void restart();
      int unsigned sub;
      sub = subframe_frames(rate) * channels * (wide ? 3 : 2);
      spp = (sub == 0) ? 0 : (PACKET_BYTES - HEADER_BYTES) / sub;
      payload_len = sub * spp;
      fill        = 0;
      payload_cnt = 0;
      first_pkt   = 1'b1;
      fc          = '0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_CHANNELS: channels = d;
        REG_RATE:     rate = d[2:0];
        REG_WIDE:     wide = d[0];
        default:      return;
      endcase
      restart();
    endfunction

    function void push_beat(byte_t b, logic l);
      pes_beat_t e;
      e.data = b;
      e.last = l;
      expected_beats.push_back(e);
    endfunction

    function void push_header();
      byte_t       h [HEADER_BYTES];
      logic [15:0] plen;
      plen = 16'(payload_len + 26);
      h = '{8'h00, 8'h00, 8'h01, 8'hBD, plen[15:8], plen[7:0],
            8'h81, first_pkt ? 8'h81 : 8'h01,
            8'h09, 8'h21, 8'h00, 8'h01, 8'h00, 8'h01,
            first_pkt ? 8'h1E : 8'hFF, first_pkt ? 8'h60 : 8'hFF,
            first_pkt ? 8'h0A : 8'hFF, 8'hFF,
            8'hA0, {3'b000, fc}, 8'h00, 8'h0A, 8'h00, 8'h09, 8'h00,
            wide ? 8'h2F : 8'h0F, 8'h0F | rate_flags(rate), 8'h00,
            8'({4'h0, channels} - 8'd1), 8'h80, 8'h00, 8'h00};
      foreach (h[i]) push_beat(h[i], 1'b0);
      first_pkt = 1'b0;
      fc = fc + 5'(spp);
    endfunction

    // accepted input byte: buffer it and predict whatever the group releases
    function void note_pcm_byte(byte_t b);
      int unsigned gsize;
      byte_t       ob;
      logic        l;
      if (spp == 0) return;
      gsize = wide ? 12 : 2;
      grp[fill] = b;
      fill++;
      if (fill < gsize) return;
      fill = 0;
      if (payload_cnt == 0) push_header();
      for (int i = 0; i < gsize; i++) begin
        ob = wide ? grp[REGROUP_24[i]] : grp[i ^ 1];
        payload_cnt++;
        l = (payload_cnt >= payload_len);
        push_beat(ob, l);
        if (l) payload_cnt = 0;
      end
    endfunction

    function void check_out_byte(byte_t d, logic l);
      pes_beat_t e;
      if (expected_beats.size() == 0) begin
        $error("out_byte: transaction with nothing expected, actual %02h", d);
        errors++;
        return;
      end
      e = expected_beats.pop_front();
      if (d !== e.data) begin
        $error("out_byte: expected %02h, actual %02h", e.data, d);
        errors++;
      end
      if (l !== e.last) begin
        $error("packet_last: expected %0b, actual %0b", e.last, l);
        errors++;
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  byte_t                  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  byte_t                  m_tdata;
  logic                   m_tlast;

  packet_stream_sb pkt_sb;
  int sender_idle_pct;
  int receiver_stall_pct;

  lpcm_pes_packetizer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) pkt_sb.check_out_byte(m_tdata, m_tlast);
  end

  task automatic send_pcm_byte(input byte_t b);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pkt_sb.note_pcm_byte(b);
  endtask

  // leaves cfg_valid high so back-to-back writes need no gap
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pkt_sb.write_register(idx, d);
  endtask

  // a partial group leaves nothing expected, so give the pipe time to settle
  task automatic drain_output();
    while (pkt_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
    s_tvalid <= 1'b0;
    drain_output();
    write_register(idx, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [3:0] ch, input logic [3:0] rate_d,
                           input logic [3:0] wide_d, input int n_bytes,
                           input int idle_pct, input int stall_pct,
                           input bit pause_mid);
    s_tvalid <= 1'b0;
    drain_output();
    write_register(REG_CHANNELS, ch);
    write_register(REG_RATE, rate_d);
    write_register(REG_WIDE, wide_d);
    cfg_valid <= 1'b0;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < n_bytes; i++) begin
      if (pause_mid && i == n_bytes / 2) begin
        s_tvalid <= 1'b0;
        drain_output();
      end
      send_pcm_byte(8'($urandom));
    end
  endtask

  initial begin
    pkt_sb = new();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset setting: 2 channels, 48k, 16-bit
    send_pcm_byte(8'h00);
    send_pcm_byte(8'hFF);
    send_pcm_byte(8'h80);
    send_pcm_byte(8'h7F);

    // 24-bit regrouping; a write to the unused index must not drop the partial group
    reconfigure(REG_WIDE, 4'd1);
    send_pcm_byte(8'h01);
    send_pcm_byte(8'hFE);
    reconfigure(CFG_INDEX_NONE, 4'hF);
    for (int i = 0; i < 10; i++) send_pcm_byte({4'(i + 2), 4'(13 - i)});

    // subframe too big for a packet: input dropped
    reconfigure(REG_CHANNELS, 4'd8);
    reconfigure(REG_RATE, 4'(RATE_192K));
    send_pcm_byte(8'hC3);
    send_pcm_byte(8'h3C);
    send_pcm_byte(8'h5A);

    // reserved rate, then zero channels: input dropped
    reconfigure(REG_RATE, 4'(RATE_RSVD6));
    send_pcm_byte(8'hA5);
    send_pcm_byte(8'h96);
    reconfigure(REG_RATE, 4'(RATE_48K));
    reconfigure(REG_CHANNELS, 4'd0);
    send_pcm_byte(8'h69);
    send_pcm_byte(8'hFF);

    run_phase(4'd13, 4'(RATE_48K),   4'd0,  60,  0,  0, 1'b1);
    // 25 subframes per packet
    run_phase(4'd1,  4'(RATE_48K),   4'd0,  80, 49,  0, 1'b0);
    run_phase(4'd8,  4'(RATE_96K),   4'd1,  60,  0, 49, 1'b0);
    run_phase(4'd15, 4'(RATE_88K2),  4'd0,  20, 31, 31, 1'b0);
    run_phase(4'd2,  4'(RATE_44K1),  4'd0,  60, 31, 31, 1'b0);
    run_phase(4'd9,  4'(RATE_48K),   4'd1,  60, 31, 31, 1'b0);
    // upper data bits of rate and width are ignored
    run_phase(4'd6,  4'hA,           4'd0,  40, 49,  0, 1'b0);
    run_phase(4'd1,  4'(RATE_176K4), 4'hF,  48,  0, 49, 1'b0);
    run_phase(4'd4,  4'(RATE_RSVD7), 4'd0,  10, 49, 49, 1'b0);
    run_phase(4'd12, 4'h9,           4'h2,  40,  0,  0, 1'b0);

    s_tvalid <= 1'b0;
    drain_output();
    repeat (40) @(posedge clk);
    if (pkt_sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
hdl/lpp_pkg.sv
hdl/lpp_setup.sv
hdl/lpp_front.sv
hdl/lpp_queue.sv
hdl/lpp_back.sv
hdl/lpcm_pes_packetizer.sv
bench/tb_lpcm_pes_packetizer.sv
